// ----- rtl/asgr_pkg.sv -----
package asgr_pkg;

   // Sizes
   localparam int SEQ_BUFFER_DEPTH_DEF = 16;
   localparam int BYTE_W               = 8;
   localparam int COLOR_W              = 4;
   localparam int WEIGHT_W             = 2;
   localparam int CSR_ADDR_W           = 1;
   localparam int CSR_DATA_W           = 4;
   localparam int REQ_DATA_W           = 8;
   // char, fg, bg, weight, italic, underline = 20 bits, padded to 24
   localparam int RSP_FIELDS_W         = 20;
   localparam int RSP_DATA_W           = 24;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_DEFAULT_FG = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEFAULT_BG = 1'b1;

   // Register reset values
   localparam logic [COLOR_W-1:0] DEFAULT_FG_RESET = 4'd15;
   localparam logic [COLOR_W-1:0] DEFAULT_BG_RESET = 4'd0;

   // Stream characters
   localparam logic [BYTE_W-1:0] CH_ESC  = 8'h1B;
   localparam logic [BYTE_W-1:0] CH_LBR  = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;
   localparam logic [BYTE_W-1:0] CH_M    = 8'h6D;
   localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
   localparam logic [BYTE_W-1:0] CH_9    = 8'h39;

   // Rendition codes
   localparam logic [7:0] SGR_RESET     = 8'd0;
   localparam logic [7:0] SGR_BOLD      = 8'd1;
   localparam logic [7:0] SGR_LIGHT     = 8'd2;
   localparam logic [7:0] SGR_ITALIC    = 8'd3;
   localparam logic [7:0] SGR_UNDERLINE = 8'd4;
   localparam logic [7:0] SGR_BLINK     = 8'd5;
   localparam logic [7:0] SGR_BLACK     = 8'd6;
   localparam logic [7:0] SGR_SWAP      = 8'd7;
   localparam logic [7:0] SGR_FG_DARK   = 8'd30;
   localparam logic [7:0] SGR_FG_DEF    = 8'd39;
   localparam logic [7:0] SGR_BG_DARK   = 8'd40;
   localparam logic [7:0] SGR_BG_DEF    = 8'd49;
   localparam logic [7:0] SGR_FG_BRIGHT = 8'd90;
   localparam logic [7:0] SGR_BG_BRIGHT = 8'd100;
   localparam logic [7:0] SGR_SPAN      = 8'd7;

   // Weight codes
   localparam logic [WEIGHT_W-1:0] WT_NORMAL = 2'd0;
   localparam logic [WEIGHT_W-1:0] WT_BOLD   = 2'd1;
   localparam logic [WEIGHT_W-1:0] WT_LIGHT  = 2'd2;
   localparam logic [WEIGHT_W-1:0] WT_BLACK  = 2'd3;

   typedef struct packed {
      logic                underline;
      logic                italic;
      logic [WEIGHT_W-1:0] weight;
      logic [COLOR_W-1:0]  bg;
      logic [COLOR_W-1:0]  fg;
   } attr_type;

   // Controller to datapath
   typedef struct packed {
      logic store;        // append request byte to sequence buffer
      logic esc_store;    // restart buffer with the ESC byte
      logic count_clear;
      logic accum_load;
      logic accum_step;
      logic accum_clear;
      logic apply;        // run accumulated code on tentative attributes
      logic commit;       // tentative result becomes current attributes
      logic tent_reload;  // tentative copy follows current attributes
      logic hold_load;    // latch breaking byte, start replay
      logic emit_direct;  // request byte to output, last
      logic emit_replay;  // buffer entry to output
      logic emit_tail;    // held byte to output, last
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_digit;
      logic is_lbr;
      logic is_semi;
      logic is_m;
      logic is_esc;
      logic buf_full;
      logic count_zero;
      logic replay_last;
      logic hold_esc;
      logic out_free;
   } status_type;

   function automatic attr_type apply_code(input attr_type a, input logic [7:0] code,
                                           input logic [COLOR_W-1:0] dfg,
                                           input logic [COLOR_W-1:0] dbg);
      attr_type   r;
      logic [7:0] diff_fd;
      logic [7:0] diff_fb;
      logic [7:0] diff_bd;
      logic [7:0] diff_bb;
      r       = a;
      diff_fd = code - SGR_FG_DARK;
      diff_fb = code - SGR_FG_BRIGHT;
      diff_bd = code - SGR_BG_DARK;
      diff_bb = code - SGR_BG_BRIGHT;
      // Codes outside every class leave the attributes alone
      if (code == SGR_RESET) begin
         r.fg        = dfg;
         r.bg        = dbg;
         r.weight    = WT_NORMAL;
         r.italic    = 1'b0;
         r.underline = 1'b0;
      end else if (code == SGR_BOLD || code == SGR_BLINK) begin
         r.weight = WT_BOLD;
      end else if (code == SGR_LIGHT) begin
         r.weight = WT_LIGHT;
      end else if (code == SGR_BLACK) begin
         r.weight = WT_BLACK;
      end else if (code == SGR_ITALIC) begin
         r.italic = 1'b1;
      end else if (code == SGR_UNDERLINE) begin
         r.underline = 1'b1;
      end else if (code == SGR_SWAP) begin
         r.fg = a.bg;
         r.bg = a.fg;
      end else if (code >= SGR_FG_DARK && code <= SGR_FG_DARK + SGR_SPAN) begin
         r.fg = {1'b0, diff_fd[2:0]};
      end else if (code == SGR_FG_DEF) begin
         r.fg = dfg;
      end else if (code >= SGR_FG_BRIGHT && code <= SGR_FG_BRIGHT + SGR_SPAN) begin
         r.fg = {1'b1, diff_fb[2:0]};
      end else if (code >= SGR_BG_DARK && code <= SGR_BG_DARK + SGR_SPAN) begin
         r.bg = {1'b0, diff_bd[2:0]};
      end else if (code == SGR_BG_DEF) begin
         r.bg = dbg;
      end else if (code >= SGR_BG_BRIGHT && code <= SGR_BG_BRIGHT + SGR_SPAN) begin
         r.bg = {1'b1, diff_bb[2:0]};
      end
      return r;
   endfunction

endpackage

// ----- rtl/asgr_ram.sv -----
module asgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port, registered read (old data on a same-address write)
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/asgr_ctrl.sv -----
module asgr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  asgr_pkg::status_type sts,
   output asgr_pkg::cmd_type    cmd
);
   import asgr_pkg::*;

   // Sequencer states
   localparam logic [1:0] ST_RUN    = 2'd0;
   localparam logic [1:0] ST_REPLAY = 2'd1;
   localparam logic [1:0] ST_TAIL   = 2'd2;

   // Parse phases
   localparam logic [1:0] PH_IDLE       = 2'd0;
   localparam logic [1:0] PH_ESC        = 2'd1;
   localparam logic [1:0] PH_NEED_DIGIT = 2'd2;
   localparam logic [1:0] PH_DIGITS     = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       accept;
   logic       broken;

   assign req_tready = (state_ff == ST_RUN) && sts.out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      phase_in = phase_ff;
      broken   = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (accept) begin
               // Classify the request against the parse phase
               unique case (phase_ff)
                  PH_ESC: begin
                     if (sts.is_lbr && !sts.buf_full) begin
                        cmd.store = 1'b1;
                        phase_in  = PH_NEED_DIGIT;
                     end else begin
                        broken = 1'b1;
                     end
                  end
                  PH_NEED_DIGIT: begin
                     if (sts.is_digit && !sts.buf_full) begin
                        cmd.store      = 1'b1;
                        cmd.accum_load = 1'b1;
                        phase_in       = PH_DIGITS;
                     end else begin
                        broken = 1'b1;
                     end
                  end
                  PH_DIGITS: begin
                     if (sts.is_m) begin
                        cmd.apply       = 1'b1;
                        cmd.commit      = 1'b1;
                        cmd.accum_clear = 1'b1;
                        cmd.count_clear = 1'b1;
                        phase_in        = PH_IDLE;
                     end else if (sts.is_digit && !sts.buf_full) begin
                        cmd.store      = 1'b1;
                        cmd.accum_step = 1'b1;
                     end else if (sts.is_semi && !sts.buf_full) begin
                        cmd.store       = 1'b1;
                        cmd.apply       = 1'b1;
                        cmd.accum_clear = 1'b1;
                        phase_in        = PH_NEED_DIGIT;
                     end else begin
                        broken = 1'b1;
                     end
                  end
                  default: begin
                     broken = 1'b1;
                  end
               endcase

               // Drop the open sequence; ESC opens a new one
               if (broken) begin
                  cmd.accum_clear = 1'b1;
                  if (sts.is_esc) begin
                     cmd.tent_reload = 1'b1;
                     cmd.esc_store   = 1'b1;
                     phase_in        = PH_ESC;
                  end else begin
                     cmd.count_clear = 1'b1;
                     phase_in        = PH_IDLE;
                  end
                  if (sts.count_zero) begin
                     cmd.emit_direct = !sts.is_esc;
                  end else begin
                     cmd.hold_load = 1'b1;
                     state_in      = ST_REPLAY;
                  end
               end
            end
         end
         ST_REPLAY: begin
            // Replay one stored byte per free output slot
            if (sts.out_free) begin
               cmd.emit_replay = 1'b1;
               if (sts.replay_last) begin
                  state_in = sts.hold_esc ? ST_RUN : ST_TAIL;
               end
            end
         end
         ST_TAIL: begin
            if (sts.out_free) begin
               cmd.emit_tail = 1'b1;
               state_in      = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         phase_ff <= PH_IDLE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- rtl/asgr_dp.sv -----
module asgr_dp #(
   parameter int SEQ_BUFFER_DEPTH = asgr_pkg::SEQ_BUFFER_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [asgr_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [asgr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [asgr_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [asgr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  asgr_pkg::cmd_type                    cmd,
   output asgr_pkg::status_type                 sts
);
   import asgr_pkg::*;

   localparam int AW = $clog2(SEQ_BUFFER_DEPTH);
   localparam int CW = $clog2(SEQ_BUFFER_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(SEQ_BUFFER_DEPTH);

   logic [BYTE_W-1:0]  req_byte;
   logic [COLOR_W-1:0] dfg_ff, dbg_ff;
   logic [7:0]         accum_ff, accum_in;
   logic [11:0]        accum_wide;
   attr_type           commit_ff, commit_in;
   attr_type           tent_ff, tent_in;
   attr_type           applied;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      len_ff;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [BYTE_W-1:0]  hold_ff;
   logic               hold_esc_ff;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [BYTE_W-1:0]  ram_rdata;
   logic               out_load;
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_char_ff, out_char_in;
   attr_type           out_attr_ff;
   logic               out_last_ff, out_last_in;

   assign req_byte = req_tdata[BYTE_W-1:0];

   // Status to the controller
   assign sts.is_digit    = (req_byte >= CH_0) && (req_byte <= CH_9);
   assign sts.is_lbr      = (req_byte == CH_LBR);
   assign sts.is_semi     = (req_byte == CH_SEMI);
   assign sts.is_m        = (req_byte == CH_M);
   assign sts.is_esc      = (req_byte == CH_ESC);
   assign sts.buf_full    = (count_ff == FULL_COUNT);
   assign sts.count_zero  = (count_ff == '0);
   assign sts.replay_last = (CW'(idx_ff) == len_ff - CW'(1));
   assign sts.hold_esc    = hold_esc_ff;
   assign sts.out_free    = !out_valid_ff || rsp_tready;

   // Default color registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dfg_ff <= DEFAULT_FG_RESET;
         dbg_ff <= DEFAULT_BG_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DEFAULT_FG: dfg_ff <= csr_wdata;
            CSR_DEFAULT_BG: dbg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Parameter accumulator, saturating at 255
   assign accum_wide = (12'(accum_ff) << 3) + (12'(accum_ff) << 1) + 12'(req_byte[3:0]);

   always_comb begin
      accum_in = accum_ff;
      if (cmd.accum_clear) begin
         accum_in = '0;
      end else if (cmd.accum_load) begin
         accum_in = 8'(req_byte[3:0]);
      end else if (cmd.accum_step) begin
         accum_in = (accum_wide > 12'd255) ? 8'd255 : accum_wide[7:0];
      end
   end

   // Attribute registers
   assign applied = apply_code(tent_ff, accum_ff, dfg_ff, dbg_ff);

   always_comb begin
      tent_in   = tent_ff;
      commit_in = commit_ff;
      if (cmd.apply) begin
         tent_in = applied;
      end
      if (cmd.commit) begin
         commit_in = applied;
      end
      if (cmd.tent_reload) begin
         tent_in = commit_ff;
      end
   end

   // Buffer fill count and replay pointer
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      if (cmd.esc_store) begin
         count_in = CW'(1);
      end else if (cmd.count_clear) begin
         count_in = '0;
      end else if (cmd.store) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.hold_load) begin
         idx_in = '0;
      end else if (cmd.emit_replay) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   // Entry 0 always holds ESC, so the restart write cannot disturb a replay
   assign ram_we    = cmd.store || cmd.esc_store;
   assign ram_waddr = cmd.esc_store ? '0 : count_ff[AW-1:0];

   asgr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (SEQ_BUFFER_DEPTH)
   ) u_buf (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_byte),
      .raddr (idx_in),
      .rdata (ram_rdata)
   );

   // Output register
   assign out_load = cmd.emit_direct || cmd.emit_replay || cmd.emit_tail;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = req_byte;
      out_last_in  = 1'b1;
      if (out_load) begin
         out_valid_in = 1'b1;
      end
      if (cmd.emit_replay) begin
         out_char_in = ram_rdata;
         out_last_in = sts.replay_last && hold_esc_ff;
      end else if (cmd.emit_tail) begin
         out_char_in = hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff     <= '0;
         commit_ff    <= '{underline: 1'b0, italic: 1'b0, weight: WT_NORMAL,
                           bg: DEFAULT_BG_RESET, fg: DEFAULT_FG_RESET};
         tent_ff      <= '{underline: 1'b0, italic: 1'b0, weight: WT_NORMAL,
                           bg: DEFAULT_BG_RESET, fg: DEFAULT_FG_RESET};
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         accum_ff     <= accum_in;
         commit_ff    <= commit_in;
         tent_ff      <= tent_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload and replay bookkeeping
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.hold_load) begin
         hold_ff     <= req_byte;
         hold_esc_ff <= sts.is_esc;
         len_ff      <= count_ff;
      end
      if (out_load) begin
         out_char_ff <= out_char_in;
         out_attr_ff <= commit_ff;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_FIELDS_W)'(0),
                        out_attr_ff.underline, out_attr_ff.italic, out_attr_ff.weight,
                        out_attr_ff.bg, out_attr_ff.fg, out_char_ff};

endmodule

// ----- rtl/ansi_sgr_attribute_decoder_core.sv -----
// Channel | Dir | Signals                          | Content
// req     | in  | req_tvalid/tready/tdata[7:0]     | byte_in
// rsp     | out | rsp_tvalid/tready/tdata/tlast    | char, attributes, last of request
// csr     | in  | csr_we/csr_addr/csr_wdata        | 0 default_fg, 1 default_bg
//
// One request per cycle while no sequence is replayed; sequence bytes give no result.
// A broken sequence of N stored bytes holds req off while they are replayed, then the
// breaking byte unless it is ESC: the buffer RAM is read one entry per free output slot.
// A single output register decouples rsp; a stalled rsp stalls req.
// Reset is synchronous; no clearing pass, stored bytes are read only after writing.
module ansi_sgr_attribute_decoder_core #(
   parameter int SEQ_BUFFER_DEPTH = asgr_pkg::SEQ_BUFFER_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [asgr_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] byte_in
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] char_out, [11:8] fg_color, [15:12] bg_color, [17:16] weight,
   // [18] italic, [19] underline, [23:20] zero
   output logic [asgr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [asgr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [asgr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import asgr_pkg::*;

   cmd_type    cmd;
   status_type sts;

   asgr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   asgr_dp #(
      .SEQ_BUFFER_DEPTH (SEQ_BUFFER_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ----- rtl/asgr_chk.sv -----
module asgr_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [asgr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import asgr_pkg::*;

   // Output register comes up empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // No request taken while the output slot is blocked
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted with output slot blocked");

   // A non-final result means a replay is under way
   a_replay_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request accepted during replay");

endmodule

bind ansi_sgr_attribute_decoder_core asgr_chk u_chk (.*);

// ----- tb/sv/sgr_render_checker.sv -----
`timescale 1ns / 100ps

// Watches the byte stream, the register writes and the styled-character
// stream, predicts every styled character and compares in order.
module sgr_render_checker #(
   parameter int DEPTH = asgr_pkg::SEQ_BUFFER_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [asgr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [asgr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [asgr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [asgr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              backlog
);
   import asgr_pkg::*;

   localparam int BRIGHT_BASE = 8;
   localparam int CODE_MAX    = 255;
   localparam int REPORT_MAX  = 10;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_ESC_SEEN,
      SEQ_NEED_DIGIT,
      SEQ_DIGITS
   } seq_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] ch;
      attr_type          attr;
      logic              last;
   } styled_char_type;

   styled_char_type     expected_chars[$];
   seq_phase_type       seq_phase;
   int                  code_accum;
   attr_type            shown_attr;
   attr_type            draft_attr;
   logic [BYTE_W-1:0]   held_bytes[DEPTH];
   int                  held_count;
   logic [COLOR_W-1:0]  dflt_fg;
   logic [COLOR_W-1:0]  dflt_bg;
   int                  misses = 0;

   // Apply one rendition code to a set of attributes
   function automatic attr_type rendition_update(input attr_type a, input int code);
      attr_type r;
      r = a;
      if (code == SGR_RESET) begin
         r.fg        = dflt_fg;
         r.bg        = dflt_bg;
         r.weight    = WT_NORMAL;
         r.italic    = 1'b0;
         r.underline = 1'b0;
      end else if (code == SGR_BOLD || code == SGR_BLINK) begin
         r.weight = WT_BOLD;
      end else if (code == SGR_LIGHT) begin
         r.weight = WT_LIGHT;
      end else if (code == SGR_BLACK) begin
         r.weight = WT_BLACK;
      end else if (code == SGR_ITALIC) begin
         r.italic = 1'b1;
      end else if (code == SGR_UNDERLINE) begin
         r.underline = 1'b1;
      end else if (code == SGR_SWAP) begin
         r.fg = a.bg;
         r.bg = a.fg;
      end else if (code >= SGR_FG_DARK && code <= SGR_FG_DARK + SGR_SPAN) begin
         r.fg = COLOR_W'(code - SGR_FG_DARK);
      end else if (code == SGR_FG_DEF) begin
         r.fg = dflt_fg;
      end else if (code >= SGR_FG_BRIGHT && code <= SGR_FG_BRIGHT + SGR_SPAN) begin
         r.fg = COLOR_W'(code - SGR_FG_BRIGHT + BRIGHT_BASE);
      end else if (code >= SGR_BG_DARK && code <= SGR_BG_DARK + SGR_SPAN) begin
         r.bg = COLOR_W'(code - SGR_BG_DARK);
      end else if (code == SGR_BG_DEF) begin
         r.bg = dflt_bg;
      end else if (code >= SGR_BG_BRIGHT && code <= SGR_BG_BRIGHT + SGR_SPAN) begin
         r.bg = COLOR_W'(code - SGR_BG_BRIGHT + BRIGHT_BASE);
      end
      return r;
   endfunction

   // Append a sequence byte; refuse when the buffer is full
   function automatic bit stash_byte(input logic [BYTE_W-1:0] ch);
      if (held_count >= DEPTH) return 1'b0;
      held_bytes[held_count] = ch;
      held_count++;
      return 1'b1;
   endfunction

   // Advance the parser by one byte and queue the characters it shows
   task automatic decode_byte(input logic [BYTE_W-1:0] ch);
      bit              digit;
      bit              broken;
      int              v;
      styled_char_type burst[$];
      styled_char_type item;
      digit  = (ch >= CH_0 && ch <= CH_9);
      broken = 1'b0;
      case (seq_phase)
         SEQ_ESC_SEEN: begin
            if (ch == CH_LBR) begin
               if (stash_byte(ch)) seq_phase = SEQ_NEED_DIGIT;
               else broken = 1'b1;
            end else begin
               broken = 1'b1;
            end
         end
         SEQ_NEED_DIGIT: begin
            if (digit) begin
               if (stash_byte(ch)) begin
                  code_accum = int'(ch) - int'(CH_0);
                  seq_phase  = SEQ_DIGITS;
               end else begin
                  broken = 1'b1;
               end
            end else begin
               broken = 1'b1;
            end
         end
         SEQ_DIGITS: begin
            if (digit) begin
               if (stash_byte(ch)) begin
                  v          = code_accum * 10 + int'(ch) - int'(CH_0);
                  code_accum = (v > CODE_MAX) ? CODE_MAX : v;
               end else begin
                  broken = 1'b1;
               end
            end else if (ch == CH_SEMI) begin
               if (stash_byte(ch)) begin
                  draft_attr = rendition_update(draft_attr, code_accum);
                  code_accum = 0;
                  seq_phase  = SEQ_NEED_DIGIT;
               end else begin
                  broken = 1'b1;
               end
            end else if (ch == CH_M) begin
               // sequence complete: commit, show nothing
               draft_attr = rendition_update(draft_attr, code_accum);
               shown_attr = draft_attr;
               code_accum = 0;
               held_count = 0;
               seq_phase  = SEQ_IDLE;
            end else begin
               broken = 1'b1;
            end
         end
         default: broken = 1'b1;
      endcase

      if (broken) begin
         // replay whatever was held, then treat the byte as if idle
         for (int i = 0; i < held_count; i++) begin
            item.ch   = held_bytes[i];
            item.attr = shown_attr;
            item.last = 1'b0;
            burst.push_back(item);
         end
         held_count = 0;
         code_accum = 0;
         seq_phase  = SEQ_IDLE;
         if (ch == CH_ESC) begin
            draft_attr    = shown_attr;
            held_bytes[0] = ch;
            held_count    = 1;
            seq_phase     = SEQ_ESC_SEEN;
         end else begin
            item.ch   = ch;
            item.attr = shown_attr;
            item.last = 1'b0;
            burst.push_back(item);
         end
      end

      // mark the final character of this request
      for (int i = 0; i < burst.size(); i++) begin
         item      = burst[i];
         item.last = (i == burst.size() - 1);
         expected_chars.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      styled_char_type got;
      styled_char_type want;
      if (reset) begin
         expected_chars.delete();
         dflt_fg              = DEFAULT_FG_RESET;
         dflt_bg              = DEFAULT_BG_RESET;
         seq_phase            = SEQ_IDLE;
         code_accum           = 0;
         held_count           = 0;
         shown_attr.fg        = DEFAULT_FG_RESET;
         shown_attr.bg        = DEFAULT_BG_RESET;
         shown_attr.weight    = WT_NORMAL;
         shown_attr.italic    = 1'b0;
         shown_attr.underline = 1'b0;
         draft_attr           = shown_attr;
      end else begin
         // compare a shown character with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.ch   = rsp_tdata[7:0];
            got.attr = attr_type'(rsp_tdata[19:8]);  // fg lowest, underline highest
            got.last = rsp_tlast;
            if (expected_chars.size() == 0) begin
               misses++;
               if (misses <= REPORT_MAX)
                  $display("%0t: unexpected character %h attrs %h last %b",
                           $realtime, got.ch, got.attr, got.last);
            end else begin
               want = expected_chars.pop_front();
               if (got.ch !== want.ch || got.attr.fg !== want.attr.fg ||
                   got.attr.bg !== want.attr.bg || got.attr.weight !== want.attr.weight ||
                   got.attr.italic !== want.attr.italic ||
                   got.attr.underline !== want.attr.underline ||
                   got.last !== want.last) begin
                  misses++;
                  if (misses <= REPORT_MAX) begin
                     $write("%0t: mismatch exp ch %h fg %0d bg %0d wt %0d it %b ul %b last %b",
                            $realtime, want.ch, want.attr.fg, want.attr.bg,
                            want.attr.weight, want.attr.italic, want.attr.underline,
                            want.last);
                     $display(" / got ch %h fg %0d bg %0d wt %0d it %b ul %b last %b",
                              got.ch, got.attr.fg, got.attr.bg, got.attr.weight,
                              got.attr.italic, got.attr.underline, got.last);
                  end
               end
            end
         end

         // track the default colors
         if (csr_we) begin
            if (csr_addr == CSR_DEFAULT_FG) dflt_fg = csr_wdata;
            else if (csr_addr == CSR_DEFAULT_BG) dflt_bg = csr_wdata;
         end

         if (req_tvalid && req_tready) decode_byte(req_tdata);
      end
      fail_count <= misses;
      backlog    <= expected_chars.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import asgr_pkg::*;

   localparam int DEPTH         = SEQ_BUFFER_DEPTH_DEF;
   localparam int RANDOM_ITEMS  = 300;
   localparam int IDLE_PCT      = 6;
   localparam int HOLD_AT       = 220;
   localparam int HOLD_CYCLES   = 300;
   localparam int CALM_FROM     = 335;
   localparam int CALM_TO       = 400;
   localparam int SETTLE_CYCLES = 24;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASES        = 4;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   int                    fail_count;
   int                    backlog;
   int                    sent_count = 0;
   wire                   calm = (sent_count >= CALM_FROM && sent_count < CALM_TO);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   ansi_sgr_attribute_decoder_core #(
      .SEQ_BUFFER_DEPTH(DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   sgr_render_checker #(
      .DEPTH(DEPTH)
   ) checker_i (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .fail_count(fail_count),
      .backlog   (backlog)
   );

   // Offer one byte, with random gaps, and hold it until taken
   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Drop valid, wait for every predicted character, then let the block go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_defaults(input logic [CSR_DATA_W-1:0] fg,
                                input logic [CSR_DATA_W-1:0] bg);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_DEFAULT_FG;
      csr_wdata <= fg;
      @(posedge clock);
      csr_addr  <= CSR_DEFAULT_BG;
      csr_wdata <= bg;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly meaningful codes, some ignored ones and some that saturate
   function automatic int pick_code();
      case ($urandom_range(7))
         0:       return $urandom_range(SGR_SWAP);
         1:       return SGR_FG_DARK + $urandom_range(SGR_SPAN);
         2:       return SGR_BG_DARK + $urandom_range(SGR_SPAN);
         3:       return SGR_FG_BRIGHT + $urandom_range(SGR_SPAN);
         4:       return SGR_BG_BRIGHT + $urandom_range(SGR_SPAN);
         5:       return $urandom_range(1) ? SGR_FG_DEF : SGR_BG_DEF;
         6:       return $urandom_range(255);
         default: return $urandom_range(99999);
      endcase
   endfunction

   // One rendition sequence; now and then damaged on purpose
   task automatic send_sgr(input int n_params);
      string digits;
      int    stray_at;
      stray_at = ($urandom_range(99) < 10) ? $urandom_range(n_params - 1) : -1;
      send_byte(CH_ESC);
      send_byte(($urandom_range(99) < 4) ? 8'($urandom_range(255)) : CH_LBR);
      for (int p = 0; p < n_params; p++) begin
         if (p > 0) send_byte(CH_SEMI);
         if ($urandom_range(99) >= 4) begin
            digits = $sformatf("%0d", pick_code());
            if ($urandom_range(9) == 0) digits = {"0", digits};
            send_text(digits);
         end
         if (p == stray_at) send_byte(8'($urandom_range(255)));
      end
      if ($urandom_range(99) >= 4) send_byte(CH_M);
   endtask

   task automatic send_random_stream(input int stop_at);
      int pick;
      while (sent_count < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            send_sgr($urandom_range(1, 4));
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(32, 126)));
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(32, 126)));
         end else begin
            repeat ($urandom_range(1, 4))
               send_byte(($urandom_range(3) == 0) ? CH_ESC : 8'($urandom_range(255)));
         end
      end
   endtask

   // Result side: random stalls, one long hold-off while requests keep coming
   initial begin
      int hold_left;
      bit held_once;
      hold_left = 0;
      held_once = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_once && sent_count >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            held_once = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      int base;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      load_defaults(4'd0, 4'd15);

      // Directed: byte extremes, every code class, damaged and over-long sequences
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("\033[1;3;4;31;42mA");
      send_text("\033[7mB");
      send_text("\033[0009999mC");
      send_text("\033[m");
      send_text("\033[5;;");
      send_text("\033[2;x");
      send_text("\033[6\033[39;49mD");
      send_text("\033\033[4mG");
      send_text("\033[1;2;6;5;95;104;");
      send_text("\033[97;107;36;44mE");
      send_text("\033[0mF");
      settle();

      // Random phases, each with its own default colors
      base = sent_count;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       load_defaults(4'd15, 4'd0);
            1:       load_defaults(4'd15, 4'd15);
            default: load_defaults(4'($urandom_range(15)), 4'($urandom_range(15)));
         endcase
         send_random_stream(base + RANDOM_ITEMS * (ph + 1) / PHASES);
         settle();
      end

      if (fail_count == 0 && backlog == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end

endmodule

// ----- ansi_sgr_attribute_decoder_core.f -----
rtl/asgr_pkg.sv
rtl/asgr_ram.sv
rtl/asgr_ctrl.sv
rtl/asgr_dp.sv
rtl/ansi_sgr_attribute_decoder_core.sv
rtl/asgr_chk.sv
tb/sv/sgr_render_checker.sv
tb/sv/testbench.sv
